// ----- sv/svg_pkg.sv -----
// Shared types and constants of the shape vertex generator.
// Request and response item structs, shape mode codes, field widths.
// No dependencies.
`default_nettype none

package svg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 16;

  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 12;
  localparam int COUNT_W  = 8;
  localparam int TURNS_W  = 4;
  localparam int RADIUS_W = 15;
  localparam int ARC_W    = 9;
  localparam int POS_W    = 16;

  localparam int ARC_MAX   = 360;
  localparam int ARC_TOTAL = 720;

  typedef enum logic [MODE_W-1:0] {
    MODE_POLY   = 3'd0,
    MODE_GAP    = 3'd1,
    MODE_SLICE  = 3'd2,
    MODE_STAR   = 3'd3,
    MODE_SPIRAL = 3'd4
  } mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  vertex_index;
    logic [COUNT_W-1:0]  count;
    logic [TURNS_W-1:0]  turns;
    logic [RADIUS_W-1:0] outer_radius;
    logic [RADIUS_W-1:0] inner_radius;
    logic [ARC_W-1:0]    arc_degrees;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    is_centre;
    logic                    is_last;
    logic                    invalid;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/svg_sin_rom.sv -----
// Quarter-wave sine table with two registered read ports.
// Contents are built at elaboration by a fixed Q30 Taylor series; uses svg_pkg.
`default_nettype none

module svg_sin_rom #(
  parameter int DEPTH  = svg_pkg::SINE_TABLE_DEPTH,
  parameter int ADDR_W = $clog2(svg_pkg::SINE_TABLE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ADDR_W-1:0]             addr_a,
  input  wire logic [ADDR_W-1:0]             addr_b,
  output logic      [svg_pkg::RADIUS_W-1:0]  data_a,
  output logic      [svg_pkg::RADIUS_W-1:0]  data_b
);
  import svg_pkg::*;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd536870912;
  localparam logic [8:0]  TAYLOR_DIV [8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                              9'd110, 9'd156, 9'd210, 9'd272};

  function automatic logic [RADIUS_W-1:0] sine_value(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
      if ((n & 1) != 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + Q30_HALF) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return RADIUS_W'(v);
  endfunction

  logic [RADIUS_W-1:0] rom [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    assign rom[k] = sine_value(k);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

`default_nettype wire

// ----- sv/shape_vertex_generator.sv -----
// Top level of the shape vertex generator: decode, products, pipelined dividers,
// sine lookup and scaling. Depends on svg_pkg and svg_sin_rom.
//
//   channel | signals                        | direction | carries
//   req     | req_valid, req_ready, req      | in        | req_t request item
//   rsp     | rsp_valid, rsp_ready, rsp      | out       | rsp_t vertex item
//
// One item per cycle sustained while the output is not stalled; the pipeline depth is
// set by the one-bit-per-stage phase divider.
// Every stage holds a valid bit; a stage advances when empty or when the next one moves,
// so bubbles close up and a stalled output stops only the full stages behind it.
// rst is synchronous and clears all valid bits; no memory clearing is needed.
`default_nettype none

module shape_vertex_generator #(
  parameter int SINE_TABLE_DEPTH = svg_pkg::SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = svg_pkg::PHASE_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire svg_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output svg_pkg::rsp_t      rsp
);
  import svg_pkg::*;

  localparam int DW  = 18;
  localparam int AW  = DW + 1;
  localparam int IB  = INDEX_W;
  localparam int RB  = RADIUS_W;
  localparam int LW  = INDEX_W;
  localparam int PW  = RADIUS_W + RADIUS_W;
  localparam int NW  = RADIUS_W + INDEX_W;
  localparam int ND  = IB + PHASE_BITS;
  localparam int NS  = ND + 8;
  localparam int TS  = ND + 3;
  localparam int QW  = PHASE_BITS - 2;
  localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {QW{1'b0}}};
  localparam logic [PW-1:0]         ROUND_HALF = PW'(16384);

  typedef struct packed {
    logic                bad;
    logic                centre;
    logic                is_last;
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  j;
    logic [INDEX_W-1:0]  i;
    logic [COUNT_W-1:0]  n;
    logic [ARC_W-1:0]    deg;
    logic [RADIUS_W-1:0] ro;
    logic [RADIUS_W-1:0] ri;
    logic [LW-1:0]       last;
  } s0_t;

  typedef struct packed {
    logic                bad;
    logic                centre;
    logic                is_last;
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  j;
    logic [INDEX_W-1:0]  i;
    logic [COUNT_W-1:0]  n;
    logic [DW-2:0]       p_dn;
    logic [DW-1:0]       p_gi;
    logic [DW-1:0]       p_si;
    logic [DW-1:0]       p_dn2;
    logic [DW-1:0]       d720;
    logic [NW-1:0]       rp;
    logic [RADIUS_W-1:0] rad;
    logic [LW-1:0]       last;
  } s1_t;

  typedef struct packed {
    logic                  bad;
    logic                  centre;
    logic                  is_last;
    logic                  star;
    logic                  spiral;
    logic [DW-1:0]         r;
    logic [DW-1:0]         d;
    logic [IB-1:0]         jb;
    logic [PHASE_BITS-1:0] q;
    logic [LW-1:0]         rr;
    logic [LW-1:0]         rd;
    logic [RB-1:0]         rn;
    logic [RB-1:0]         rq;
    logic [RB-1:0]         rad;
  } dv_t;

  typedef struct packed {
    logic                  bad;
    logic                  centre;
    logic                  is_last;
    logic [RB-1:0]         rad;
    logic [PHASE_BITS-1:0] sp;
    logic [PHASE_BITS-1:0] cp;
  } t0_t;

  typedef struct packed {
    logic          bad;
    logic          centre;
    logic          is_last;
    logic [RB-1:0] rad;
    logic [IW-1:0] s_addr;
    logic [IW-1:0] c_addr;
    logic          s_neg;
    logic          c_neg;
  } t1_t;

  typedef struct packed {
    logic          bad;
    logic          centre;
    logic          is_last;
    logic [RB-1:0] rad;
    logic          s_neg;
    logic          c_neg;
  } t2_t;

  typedef struct packed {
    logic          bad;
    logic          centre;
    logic          is_last;
    logic [PW-1:0] s_prod;
    logic [PW-1:0] c_prod;
    logic          s_neg;
    logic          c_neg;
  } t3_t;

  logic [NS-1:0] v;
  logic [NS:0]   adv;

  assign adv[NS] = rsp_ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = ~v[k] | adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= req_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign req_ready = adv[0];
  assign rsp_valid = v[NS-1];

  // decode
  s0_t              s0, s0_next;
  logic [ARC_W-1:0] deg_sat;
  logic [LW-1:0]    last_sp, last_sel;
  logic [COUNT_W:0] last_fan;
  logic             spiral_in;

  always_comb begin
    deg_sat   = (req.arc_degrees > ARC_W'(ARC_MAX)) ? ARC_W'(ARC_MAX) : req.arc_degrees;
    spiral_in = (req.mode == MODE_SPIRAL);
    last_sp   = LW'(req.turns) * LW'(req.count);
    last_fan  = (req.mode == MODE_STAR) ? {req.count, 1'b1}
                                        : (COUNT_W + 1)'(req.count) + (COUNT_W + 1)'(1);
    last_sel  = spiral_in ? last_sp : LW'(last_fan);
    s0_next.bad = (req.mode > MODE_SPIRAL) || (req.count == '0) ||
                  (spiral_in ? ((req.turns == '0) || (req.vertex_index > last_sp))
                             : (req.vertex_index > LW'(last_fan)));
    s0_next.centre  = !s0_next.bad && !spiral_in && (req.vertex_index == '0);
    s0_next.is_last = !s0_next.bad && (req.vertex_index == last_sel);
    s0_next.mode    = req.mode;
    s0_next.j       = req.vertex_index;
    s0_next.i       = req.vertex_index - INDEX_W'(1);
    s0_next.n       = req.count;
    s0_next.deg     = deg_sat;
    s0_next.ro      = req.outer_radius;
    s0_next.ri      = req.inner_radius;
    s0_next.last    = last_sp;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0 <= s0_next;
    end
  end

  // products
  s1_t              s1, s1_next;
  logic [ARC_W:0]   two_deg, gap_w, slice_w;
  logic [COUNT_W-1:0] i8;

  always_comb begin
    i8      = s0.i[COUNT_W-1:0];
    two_deg = {s0.deg, 1'b0};
    gap_w   = (ARC_W + 1)'(ARC_TOTAL) - two_deg;
    slice_w = (ARC_W + 1)'(ARC_TOTAL) - (ARC_W + 1)'(s0.deg);
    s1_next.bad     = s0.bad;
    s1_next.centre  = s0.centre;
    s1_next.is_last = s0.is_last;
    s1_next.mode    = s0.mode;
    s1_next.j       = s0.j;
    s1_next.i       = s0.i;
    s1_next.n       = s0.n;
    s1_next.p_dn    = (DW - 1)'(s0.deg) * (DW - 1)'(s0.n);
    s1_next.p_gi    = DW'(gap_w) * DW'(i8);
    s1_next.p_si    = DW'(two_deg) * DW'(i8);
    s1_next.p_dn2   = DW'(slice_w) * DW'(s0.n);
    s1_next.d720    = DW'(ARC_TOTAL) * DW'(s0.n);
    s1_next.rp      = NW'(s0.ro) * NW'(s0.j);
    s1_next.rad     = ((s0.mode == MODE_STAR) && s0.i[0]) ? s0.ri : s0.ro;
    s1_next.last    = s0.last;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1 <= s1_next;
    end
  end

  // numerator select and first reduction
  dv_t           dv [ND+1];
  dv_t           dv_next [ND+1];
  logic [AW-1:0] num;
  logic [DW-1:0] den;

  always_comb begin
    unique case (s1.mode)
      MODE_POLY: begin
        num = AW'(s1.i);
        den = DW'(s1.n);
      end
      MODE_GAP: begin
        num = AW'(s1.p_dn) + AW'(s1.p_gi);
        den = s1.d720;
      end
      MODE_SLICE: begin
        num = AW'(s1.p_si) + AW'(s1.p_dn2);
        den = s1.d720;
      end
      MODE_STAR: begin
        num = AW'(s1.i);
        den = {{(DW - COUNT_W - 1){1'b0}}, s1.n, 1'b0};
      end
      default: begin
        num = '0;
        den = DW'(s1.n);
      end
    endcase
    dv_next[0].bad     = s1.bad;
    dv_next[0].centre  = s1.centre;
    dv_next[0].is_last = s1.is_last;
    dv_next[0].star    = (s1.mode == MODE_STAR);
    dv_next[0].spiral  = (s1.mode == MODE_SPIRAL);
    dv_next[0].r       = (num >= AW'(den)) ? DW'(num - AW'(den)) : DW'(num);
    dv_next[0].d       = den;
    dv_next[0].jb      = s1.j;
    dv_next[0].q       = '0;
    dv_next[0].rr      = s1.rp[NW-1:RB];
    dv_next[0].rd      = s1.last;
    dv_next[0].rn      = s1.rp[RB-1:0];
    dv_next[0].rq      = '0;
    dv_next[0].rad     = s1.rad;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dv[0] <= dv_next[0];
    end
  end

  // divider steps: integer part of the spiral index, then phase fraction,
  // with the spiral radius quotient alongside
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [DW:0] t;
    logic        ge;
    logic [LW:0] t2;
    logic        ge2;
    dv_t         nx;

    if (k < IB) begin : g_int
      assign t  = {dv[k].r, dv[k].jb[IB-1-k]};
      assign ge = t >= {1'b0, dv[k].d};
    end else begin : g_frac
      assign t  = {dv[k].r, 1'b0};
      assign ge = t >= {1'b0, dv[k].d};
    end

    if (k < RB) begin : g_rad
      assign t2  = {dv[k].rr, dv[k].rn[RB-1-k]};
      assign ge2 = t2 >= {1'b0, dv[k].rd};
    end else begin : g_rad_hold
      assign t2  = {1'b0, dv[k].rr};
      assign ge2 = 1'b0;
    end

    always_comb begin
      nx = dv[k];
      if (k < IB) begin
        if (dv[k].spiral) begin
          nx.r = ge ? DW'(t - {1'b0, dv[k].d}) : DW'(t);
        end
      end else begin
        nx.r = ge ? DW'(t - {1'b0, dv[k].d}) : DW'(t);
        nx.q = {dv[k].q[PHASE_BITS-2:0], ge};
      end
      if (k < RB) begin
        nx.rr = ge2 ? LW'(t2 - {1'b0, dv[k].rd}) : LW'(t2);
        nx.rq = {dv[k].rq[RB-2:0], ge2};
      end
      dv_next[k+1] = nx;
    end

    always_ff @(posedge clk) begin
      if (adv[k+3]) begin
        dv[k+1] <= dv_next[k+1];
      end
    end
  end

  // phase offsets
  t0_t t0, t0_next;

  always_comb begin
    t0_next.bad     = dv[ND].bad;
    t0_next.centre  = dv[ND].centre;
    t0_next.is_last = dv[ND].is_last;
    t0_next.rad     = dv[ND].spiral ? dv[ND].rq : dv[ND].rad;
    t0_next.sp      = dv[ND].star ? dv[ND].q + QUARTER : dv[ND].q;
    t0_next.cp      = dv[ND].star ? dv[ND].q + {QUARTER[PHASE_BITS-2:0], 1'b0}
                                  : dv[ND].q + QUARTER;
  end

  always_ff @(posedge clk) begin
    if (adv[TS]) begin
      t0 <= t0_next;
    end
  end

  // quadrant fold and table index
  t1_t              t1, t1_next;
  logic [QW+IW-1:0] s_full, c_full;
  logic [IW-1:0]    s_idx, c_idx;

  always_comb begin
    s_full = (QW + IW)'(t0.sp[QW-1:0]) * (QW + IW)'(SINE_TABLE_DEPTH);
    c_full = (QW + IW)'(t0.cp[QW-1:0]) * (QW + IW)'(SINE_TABLE_DEPTH);
    s_idx  = IW'(s_full >> QW);
    c_idx  = IW'(c_full >> QW);
    t1_next.bad     = t0.bad;
    t1_next.centre  = t0.centre;
    t1_next.is_last = t0.is_last;
    t1_next.rad     = t0.rad;
    t1_next.s_addr  = t0.sp[PHASE_BITS-2] ? IW'(SINE_TABLE_DEPTH) - s_idx : s_idx;
    t1_next.c_addr  = t0.cp[PHASE_BITS-2] ? IW'(SINE_TABLE_DEPTH) - c_idx : c_idx;
    t1_next.s_neg   = t0.sp[PHASE_BITS-1];
    t1_next.c_neg   = t0.cp[PHASE_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (adv[TS+1]) begin
      t1 <= t1_next;
    end
  end

  // table read
  t2_t                 t2;
  logic [RADIUS_W-1:0] s_mag, c_mag;

  svg_sin_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (IW)
  ) u_rom (
    .clk    (clk),
    .en     (adv[TS+2]),
    .addr_a (t1.s_addr),
    .addr_b (t1.c_addr),
    .data_a (s_mag),
    .data_b (c_mag)
  );

  always_ff @(posedge clk) begin
    if (adv[TS+2]) begin
      t2.bad     <= t1.bad;
      t2.centre  <= t1.centre;
      t2.is_last <= t1.is_last;
      t2.rad     <= t1.rad;
      t2.s_neg   <= t1.s_neg;
      t2.c_neg   <= t1.c_neg;
    end
  end

  // scale by radius
  t3_t t3;

  always_ff @(posedge clk) begin
    if (adv[TS+3]) begin
      t3.bad     <= t2.bad;
      t3.centre  <= t2.centre;
      t3.is_last <= t2.is_last;
      t3.s_prod  <= PW'(t2.rad) * PW'(s_mag);
      t3.c_prod  <= PW'(t2.rad) * PW'(c_mag);
      t3.s_neg   <= t2.s_neg;
      t3.c_neg   <= t2.c_neg;
    end
  end

  // round, sign and output register
  rsp_t                rsp_next;
  logic [RADIUS_W-1:0] s_m, c_m;
  logic                zero_pos;

  always_comb begin
    s_m      = RADIUS_W'((t3.s_prod + ROUND_HALF) >> RADIUS_W);
    c_m      = RADIUS_W'((t3.c_prod + ROUND_HALF) >> RADIUS_W);
    zero_pos = t3.bad | t3.centre;
    rsp_next.pos_x     = zero_pos ? '0 : (t3.c_neg ? -POS_W'(c_m) : POS_W'(c_m));
    rsp_next.pos_y     = zero_pos ? '0 : (t3.s_neg ? -POS_W'(s_m) : POS_W'(s_m));
    rsp_next.is_centre = t3.centre;
    rsp_next.is_last   = t3.is_last;
    rsp_next.invalid   = t3.bad;
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("request side stalled without a stalled output");

  a_invalid_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.invalid) |-> (rsp.pos_x == '0 && rsp.pos_y == '0 &&
                                    !rsp.is_centre && !rsp.is_last))
    else $error("invalid item carries position or flags");

  a_centre_at_origin: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_centre) |-> (rsp.pos_x == '0 && rsp.pos_y == '0 && !rsp.is_last))
    else $error("centre item not at origin");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench of shape_vertex_generator: random and directed vertex
// requests, a built-in vertex predictor and an in-order scoreboard class.
// Depends on svg_pkg and the shape_vertex_generator RTL.
`default_nettype none

module tb;
  import svg_pkg::*;

  localparam int LATENCY   = INDEX_W + PHASE_BITS + 8;
  localparam int CYCLE_CAP = 400000;
  localparam longint TURN  = 64'd1 << PHASE_BITS;

  int sine_lut [0:SINE_TABLE_DEPTH];

  class vertex_scoreboard;
    rsp_t pending[$];
    int mismatches;
    int checked;

    function void note(rsp_t r);
      pending.insert(pending.size(), r);
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex item %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.is_centre !== want.is_centre || got.is_last !== want.is_last ||
          got.invalid !== want.invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex mismatch: want x=%0d y=%0d c=%b l=%b i=%b, got x=%0d y=%0d c=%b l=%b i=%b",
                   want.pos_x, want.pos_y, want.is_centre, want.is_last, want.invalid,
                   got.pos_x, got.pos_y, got.is_centre, got.is_last, got.invalid);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  vertex_scoreboard sb;
  int cycles = 0;
  bit idle_enable = 1'b1;
  int sent = 0;

  shape_vertex_generator dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void build_sine();
    longint unsigned x, x2, term, sum, v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (longint'(k) * (64'd3373259426 / 2)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n & 1) sum = (sum >= term) ? sum - term : 0;
        else sum += term;
      end
      v = (sum * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      sine_lut[k] = int'(v);
    end
  endfunction

  function automatic int sine_of(longint unsigned p);
    int quad, v;
    longint unsigned rem, idx;
    p &= TURN - 1;
    quad = int'((p >> (PHASE_BITS - 2)) & 3);
    rem = p & ((TURN >> 2) - 1);
    idx = (rem * SINE_TABLE_DEPTH) >> (PHASE_BITS - 2);
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    v = quad[0] ? sine_lut[SINE_TABLE_DEPTH - idx] : sine_lut[idx];
    return quad[1] ? -v : v;
  endfunction

  function automatic int scale_coord(longint unsigned r, int s);
    longint unsigned mag;
    int m;
    mag = (s < 0) ? -s : s;
    m = int'((r * mag + 16384) >> 15);
    return (s < 0) ? -m : m;
  endfunction

  function automatic rsp_t predict_vertex(req_t q);
    rsp_t r;
    longint unsigned md, j, n, tn, ro, ri, deg, ph, rad, i, last;
    bit bad, ctr, lst;
    int x, y;
    md = q.mode; j = q.vertex_index; n = q.count; tn = q.turns;
    ro = q.outer_radius; ri = q.inner_radius; deg = q.arc_degrees;
    ph = 0; rad = ro; bad = 0; ctr = 0; lst = 0; x = 0; y = 0;
    if (deg > ARC_MAX) deg = ARC_MAX;
    if (md > MODE_SPIRAL || n == 0) bad = 1;
    else if (md == MODE_SPIRAL) begin
      last = tn * n;
      if (tn == 0 || j > last) bad = 1;
      else begin
        ph = (j * TURN) / n;
        rad = (ro * j) / last;
        lst = (j == last);
      end
    end else begin
      last = (md == MODE_STAR) ? 2 * n + 1 : n + 1;
      if (j > last) bad = 1;
      else if (j == 0) ctr = 1;
      else begin
        i = j - 1;
        lst = (j == last);
        case (md)
          MODE_POLY:  ph = (i * TURN) / n;
          MODE_GAP:   ph = (TURN * (deg * n + (ARC_TOTAL - 2 * deg) * i)) / (ARC_TOTAL * n);
          MODE_SLICE: ph = (TURN * (2 * deg * i + (ARC_TOTAL - deg) * n)) / (ARC_TOTAL * n);
          default: begin
            ph = (TURN >> 2) + (i * TURN) / (2 * n);
            rad = i[0] ? ri : ro;
          end
        endcase
      end
    end
    if (!bad && !ctr) begin
      x = scale_coord(rad, sine_of(ph + (TURN >> 2)));
      y = scale_coord(rad, sine_of(ph));
    end
    if (bad) lst = 0;
    r.pos_x = x[POS_W-1:0];
    r.pos_y = y[POS_W-1:0];
    r.is_centre = ctr;
    r.is_last = lst;
    r.invalid = bad;
    return r;
  endfunction

  task automatic send_vertex(req_t q);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note(predict_vertex(q));
    sent++;
  endtask

  function automatic req_t make_req(int md, int j, int n, int t, int ro, int ri, int d);
    req_t q;
    q.mode = md[MODE_W-1:0];
    q.vertex_index = j[INDEX_W-1:0];
    q.count = n[COUNT_W-1:0];
    q.turns = t[TURNS_W-1:0];
    q.outer_radius = ro[RADIUS_W-1:0];
    q.inner_radius = ri[RADIUS_W-1:0];
    q.arc_degrees = d[ARC_W-1:0];
    return q;
  endfunction

  function automatic req_t random_req();
    int md, n, t, last, j;
    md = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
    t = $urandom_range(0, 15);
    if (md == MODE_SPIRAL) last = t * n;
    else if (md == MODE_STAR) last = 2 * n + 1;
    else last = n + 1;
    if ($urandom_range(0, 9) == 0) j = $urandom_range(0, 4095);
    else j = $urandom_range(0, last + 1);
    return make_req(md, j, n, t, $urandom_range(0, 32767), $urandom_range(0, 32767),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(361, 511)
                                                : $urandom_range(0, 360));
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check(rsp);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : rsp_side
    int stall;
    @(negedge rst);
    forever begin
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : req_side
    sb = new();
    build_sine();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_vertex(make_req(MODE_POLY, 0, 6, 1, 32767, 0, 0));
    send_vertex(make_req(MODE_POLY, 1, 6, 1, 32767, 0, 0));
    send_vertex(make_req(MODE_POLY, 7, 6, 1, 32767, 0, 0));
    send_vertex(make_req(MODE_POLY, 8, 6, 1, 32767, 0, 0));
    send_vertex(make_req(MODE_POLY, 4095, 255, 15, 32767, 32767, 511));
    send_vertex(make_req(MODE_POLY, 3, 0, 1, 1000, 0, 0));
    send_vertex(make_req(MODE_GAP, 2, 12, 0, 20000, 0, 40));
    send_vertex(make_req(MODE_GAP, 13, 12, 0, 20000, 0, 0));
    send_vertex(make_req(MODE_GAP, 5, 12, 0, 20000, 0, 400));
    send_vertex(make_req(MODE_SLICE, 1, 8, 0, 30000, 0, 50));
    send_vertex(make_req(MODE_SLICE, 9, 8, 0, 30000, 0, 360));
    send_vertex(make_req(MODE_SLICE, 4, 255, 0, 32767, 0, 180));
    send_vertex(make_req(MODE_STAR, 1, 5, 0, 32767, 12000, 0));
    send_vertex(make_req(MODE_STAR, 2, 5, 0, 32767, 12000, 0));
    send_vertex(make_req(MODE_STAR, 11, 5, 0, 32767, 12000, 0));
    send_vertex(make_req(MODE_STAR, 12, 5, 0, 32767, 12000, 0));
    send_vertex(make_req(MODE_SPIRAL, 0, 10, 3, 32767, 0, 0));
    send_vertex(make_req(MODE_SPIRAL, 30, 10, 3, 32767, 0, 0));
    send_vertex(make_req(MODE_SPIRAL, 31, 10, 3, 32767, 0, 0));
    send_vertex(make_req(MODE_SPIRAL, 5, 10, 0, 32767, 0, 0));
    send_vertex(make_req(MODE_SPIRAL, 4095, 255, 15, 32767, 32767, 0));
    send_vertex(make_req(5, 1, 4, 1, 100, 100, 10));
    send_vertex(make_req(7, 0, 4, 1, 100, 100, 10));
    for (int k = 0; k < 500; k++) begin
      if (k == 420) idle_enable = 1'b0;
      send_vertex(random_req());
    end
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d vertex requests over all five shape modes and bad cases; %0d checked.",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- shape_vertex_generator.f -----
sv/svg_pkg.sv
sv/svg_sin_rom.sv
sv/shape_vertex_generator.sv
sim/tb.sv
